// ===== hdl/poi_pkg.sv =====
// shared types, constants and the arctangent table for the odometry integrator
// no dependencies
package poi_pkg;

	localparam int TrigIterationsDefault = 16;
	localparam int TrigIterationsMax = 24;
	localparam logic signed [33:0] CordicStart = 34'sd652032874;
	localparam logic signed [23:0] HeadingScale = 24'sd5734161;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_ROT,
		ST_FIN,
		ST_MUL,
		ST_DONE
	} state_t;

	function automatic logic [33:0] atan_entry(input logic [4:0] idx);
		logic [33:0] r;
		unique case (idx)
			5'd0:  r = 34'h020000000;
			5'd1:  r = 34'h012E4051E;
			5'd2:  r = 34'h009FB385B;
			5'd3:  r = 34'h0051111D4;
			5'd4:  r = 34'h0028B0D43;
			5'd5:  r = 34'h00145D7E1;
			5'd6:  r = 34'h000A2F61E;
			5'd7:  r = 34'h000517C55;
			5'd8:  r = 34'h00028BE53;
			5'd9:  r = 34'h000145F2F;
			5'd10: r = 34'h0000A2F98;
			5'd11: r = 34'h0000517CC;
			5'd12: r = 34'h000028BE6;
			5'd13: r = 34'h0000145F3;
			5'd14: r = 34'h00000A2FA;
			5'd15: r = 34'h00000517D;
			5'd16: r = 34'h0000028BE;
			5'd17: r = 34'h00000145F;
			5'd18: r = 34'h000000A30;
			5'd19: r = 34'h000000518;
			5'd20: r = 34'h00000028C;
			5'd21: r = 34'h000000146;
			5'd22: r = 34'h0000000A3;
			5'd23: r = 34'h000000051;
			default: r = 34'h000000000;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/planar_odometry_integrator_core.sv =====
// planar dead-reckoning odometry integrator, top level
// depends on poi_pkg (arctangent table, state type, constants)
// a new input beat is taken only in the idle state, after the previous result has been
// handed to the output register, and is held off longer while a result waits; the shared
// cordic datapath and the single multiplier are each used in turn
// reset: arst_n low clears position, heading, sequencer and output valid flag at once
module planar_odometry_integrator_core #(
	parameter int TRIG_ITERATIONS = poi_pkg::TrigIterationsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  velocity_x,
	input  logic signed [15:0]  velocity_y,
	input  logic signed [15:0]  turn_rate,
	input  logic        [19:0]  time_step,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [47:0]  position_x,
	output logic signed [47:0]  position_y,
	output logic        [31:0]  heading_angle,
	output logic signed [15:0]  quat_z,
	output logic signed [15:0]  quat_w,
	output logic signed [15:0]  echo_velocity_x,
	output logic signed [15:0]  echo_velocity_y,
	output logic signed [15:0]  echo_turn_rate
);

	// rotation count, capped at the table length
	localparam int NumIter = (TRIG_ITERATIONS > poi_pkg::TrigIterationsMax) ?
		poi_pkg::TrigIterationsMax : TRIG_ITERATIONS;
	localparam logic [4:0] LastIter = 5'(NumIter - 1);
	localparam logic [3:0] LastMul = 4'd8;

	poi_pkg::state_t state_q, state_d;

	// architectural state
	logic signed [47:0] pos_x_q, pos_y_q;
	logic        [31:0] heading_q;

	// latched input beat
	logic signed [15:0] vx_q, vy_q, wz_q;
	logic        [19:0] dt_q;

	// cordic registers
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic        [4:0]  iter_q;
	logic               pass_q; // 0: rotation angle, 1: half angle for quaternion

	// sine/cosine of the latest cordic pass
	logic signed [15:0] sin_q, cos_q;

	// multiply sequencer
	logic        [3:0]  mstep_q;
	logic signed [59:0] prod_q;
	logic signed [32:0] tmp_q;
	logic signed [32:0] ex_q, ey_q;

	// output register
	logic               out_valid_q;
	logic signed [47:0] res_px_q, res_py_q;
	logic        [31:0] res_hd_q;
	logic signed [15:0] res_qz_q, res_qw_q, res_vx_q, res_vy_q, res_wz_q;

	// fold of the start angle into [-pi/2, pi/2]
	logic        [31:0] fold_angle;
	logic signed [33:0] fold_z;
	logic               fold_flip;

	// one cordic micro-rotation
	logic signed [33:0] xs, ys, rot_x, rot_y, rot_z, atan_v;

	// final rounding to q1.15
	logic signed [33:0] fin_x, fin_y, rnd_x, rnd_y;
	logic signed [15:0] sat_x, sat_y;

	// shared multiplier
	logic signed [35:0] mul_a;
	logic signed [23:0] mul_b;
	logic signed [59:0] mul_p;

	// position and heading update from the product register
	logic signed [59:0] rnd_pos, rnd_hd;
	logic signed [48:0] pos_sum;
	logic signed [47:0] pos_base, pos_new;
	logic        [31:0] heading_new;

	logic in_fire, out_fire;

	assign in_ready  = (state_q == poi_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		fold_angle = pass_q ? heading_q : {heading_q[30:0], 1'b0};
		fold_z     = 34'(signed'(fold_angle));
		fold_flip  = 1'b0;
		if (fold_z > 34'sd1073741824) begin
			fold_z    = fold_z - 34'sd2147483648;
			fold_flip = 1'b1;
		end else if (fold_z < -34'sd1073741824) begin
			fold_z    = fold_z + 34'sd2147483648;
			fold_flip = 1'b1;
		end
	end

	always_comb begin
		xs     = cx_q >>> iter_q;
		ys     = cy_q >>> iter_q;
		atan_v = signed'(poi_pkg::atan_entry(iter_q));
		if (!cz_q[33]) begin
			rot_x = cx_q - ys;
			rot_y = cy_q + xs;
			rot_z = cz_q - atan_v;
		end else begin
			rot_x = cx_q + ys;
			rot_y = cy_q - xs;
			rot_z = cz_q + atan_v;
		end
	end

	always_comb begin
		fin_x = flip_q ? -cx_q : cx_q;
		fin_y = flip_q ? -cy_q : cy_q;
		rnd_x = (fin_x + 34'sd16384) >>> 15;
		rnd_y = (fin_y + 34'sd16384) >>> 15;
		if (rnd_x > 34'sd32767)       sat_x = 16'sh7FFF;
		else if (rnd_x < -34'sd32768) sat_x = 16'sh8000;
		else                          sat_x = rnd_x[15:0];
		if (rnd_y > 34'sd32767)       sat_y = 16'sh7FFF;
		else if (rnd_y < -34'sd32768) sat_y = 16'sh8000;
		else                          sat_y = rnd_y[15:0];
	end

	// operand select for each multiply step
	always_comb begin
		mul_a = 36'sd0;
		mul_b = 24'sd0;
		unique case (mstep_q)
			4'd0: begin mul_a = 36'(vx_q); mul_b = 24'(cos_q); end
			4'd1: begin mul_a = 36'(vy_q); mul_b = 24'(sin_q); end
			4'd2: begin mul_a = 36'(vx_q); mul_b = 24'(sin_q); end
			4'd3: begin mul_a = 36'(vy_q); mul_b = 24'(cos_q); end
			4'd4: begin mul_a = 36'(ex_q); mul_b = 24'(signed'({1'b0, dt_q})); end
			4'd5: begin mul_a = 36'(ey_q); mul_b = 24'(signed'({1'b0, dt_q})); end
			4'd6: begin mul_a = 36'(wz_q); mul_b = 24'(signed'({1'b0, dt_q})); end
			4'd7: begin mul_a = prod_q[35:0]; mul_b = poi_pkg::HeadingScale; end
			default: begin mul_a = 36'sd0; mul_b = 24'sd0; end
		endcase
		mul_p = 60'(mul_a) * 60'(mul_b);
	end

	// steps 5 and 6 land the x and y position terms, step 8 the heading term
	always_comb begin
		rnd_pos  = prod_q + 60'sd16384;
		pos_base = (mstep_q == 4'd5) ? pos_x_q : pos_y_q;
		pos_sum  = 49'(pos_base) + 49'(signed'(rnd_pos[59:15]));
		if (pos_sum[48] != pos_sum[47])
			pos_new = pos_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			pos_new = pos_sum[47:0];
		rnd_hd      = prod_q + 60'sd8388608;
		heading_new = heading_q + rnd_hd[55:24];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= poi_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			poi_pkg::ST_IDLE: if (in_fire) state_d = poi_pkg::ST_FOLD;
			poi_pkg::ST_FOLD: state_d = poi_pkg::ST_ROT;
			poi_pkg::ST_ROT:  if (iter_q == LastIter) state_d = poi_pkg::ST_FIN;
			poi_pkg::ST_FIN:  state_d = pass_q ? poi_pkg::ST_DONE : poi_pkg::ST_MUL;
			poi_pkg::ST_MUL:  if (mstep_q == LastMul) state_d = poi_pkg::ST_FOLD;
			poi_pkg::ST_DONE: if (!out_valid_q || out_ready) state_d = poi_pkg::ST_IDLE;
			default:          state_d = poi_pkg::ST_IDLE;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			heading_q   <= '0;
			pass_q      <= 1'b0;
			iter_q      <= '0;
			mstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_fire) out_valid_q <= 1'b0;
			unique case (state_q)
				poi_pkg::ST_IDLE: begin
					pass_q <= 1'b0;
				end
				poi_pkg::ST_FOLD: begin
					iter_q <= '0;
				end
				poi_pkg::ST_ROT: begin
					iter_q <= iter_q + 5'd1;
				end
				poi_pkg::ST_FIN: begin
					mstep_q <= '0;
				end
				poi_pkg::ST_MUL: begin
					mstep_q <= mstep_q + 4'd1;
					if (mstep_q == 4'd5) pos_x_q <= pos_new;
					if (mstep_q == 4'd6) pos_y_q <= pos_new;
					if (mstep_q == LastMul) begin
						heading_q <= heading_new;
						pass_q    <= 1'b1;
					end
				end
				poi_pkg::ST_DONE: begin
					if (!out_valid_q || out_ready) out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			vx_q <= velocity_x;
			vy_q <= velocity_y;
			wz_q <= turn_rate;
			dt_q <= time_step;
		end
		unique case (state_q)
			poi_pkg::ST_FOLD: begin
				cx_q   <= poi_pkg::CordicStart;
				cy_q   <= '0;
				cz_q   <= fold_z;
				flip_q <= fold_flip;
			end
			poi_pkg::ST_ROT: begin
				cx_q <= rot_x;
				cy_q <= rot_y;
				cz_q <= rot_z;
			end
			poi_pkg::ST_FIN: begin
				// second pass holds the quaternion until the result register is free
				sin_q <= sat_y;
				cos_q <= sat_x;
			end
			poi_pkg::ST_MUL: begin
				prod_q <= mul_p;
				if (mstep_q == 4'd1 || mstep_q == 4'd3) tmp_q <= 33'(prod_q);
				if (mstep_q == 4'd2) ex_q <= tmp_q - 33'(prod_q);
				if (mstep_q == 4'd4) ey_q <= tmp_q + 33'(prod_q);
			end
			poi_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					res_px_q <= pos_x_q;
					res_py_q <= pos_y_q;
					res_hd_q <= heading_q;
					res_qz_q <= sin_q;
					res_qw_q <= cos_q;
					res_vx_q <= vx_q;
					res_vy_q <= vy_q;
					res_wz_q <= wz_q;
				end
			end
			default: ;
		endcase
	end

	assign position_x      = res_px_q;
	assign position_y      = res_py_q;
	assign heading_angle   = res_hd_q;
	assign quat_z          = res_qz_q;
	assign quat_w          = res_qw_q;
	assign echo_velocity_x = res_vx_q;
	assign echo_velocity_y = res_vy_q;
	assign echo_turn_rate  = res_wz_q;

endmodule
